@@ rtl/cnts_pkg.sv @@
// Shared types and constants for the two-species coordination counter.
package cnts_pkg;

   localparam int MaxAtoms   = 64;
   localparam int CoordWidth = 24;
   localparam int SpecWidth  = 8;
   localparam int OutWidth   = 6;
   localparam int DiffWidth  = 26;
   localparam int SqWidth    = 2 * DiffWidth;
   localparam int SumWidth   = SqWidth + 2;
   localparam int CutSqWidth = 2 * CoordWidth;
   localparam int AddrWidth  = 5;
   localparam int DataWidth  = 32;

   localparam logic [2:0] RegBoxX      = 3'd0;
   localparam logic [2:0] RegBoxY      = 3'd1;
   localparam logic [2:0] RegBoxZ      = 3'd2;
   localparam logic [2:0] RegInner     = 3'd3;
   localparam logic [2:0] RegOuter     = 3'd4;
   localparam logic [2:0] RegCenterSpc = 3'd5;
   localparam logic [2:0] RegNbrSpc    = 3'd6;

   typedef struct packed {
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
      logic [CoordWidth-1:0] z;
      logic [SpecWidth-1:0]  species;
   } atom_slot_type;

   typedef struct packed {
      logic valid;
      logic pair_ok;
      logic last_step;
      logic is_center;
   } tag_type;

endpackage

@@ rtl/cnts_if.sv @@
// Input and result channel interfaces.
interface cnts_req_if;
   logic                              valid;
   logic                              ready;
   logic [cnts_pkg::CoordWidth-1:0]   coord_x;
   logic [cnts_pkg::CoordWidth-1:0]   coord_y;
   logic [cnts_pkg::CoordWidth-1:0]   coord_z;
   logic [cnts_pkg::SpecWidth-1:0]    species;
   logic                              last_atom;
   modport source (output valid, coord_x, coord_y, coord_z, species, last_atom, input ready);
   modport sink   (input valid, coord_x, coord_y, coord_z, species, last_atom, output ready);
endinterface

interface cnts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cnts_pkg::OutWidth-1:0]     center_index;
   logic [cnts_pkg::OutWidth-1:0]     neighbor_count;
   logic                              last_result;
   logic                              none_found;
   modport source (output valid, center_index, neighbor_count, last_result, none_found,
                   input ready);
   modport sink   (input valid, center_index, neighbor_count, last_result, none_found,
                   output ready);
endinterface

@@ rtl/cnts_cell.sv @@
// One atom slot of the rotating storage ring.
module cnts_cell (
   input  logic                     clock,
   input  logic                     shift,
   input  cnts_pkg::atom_slot_type  atom_in,
   output cnts_pkg::atom_slot_type  atom_out
);
   cnts_pkg::atom_slot_type atom_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         atom_ff <= atom_in;
      end
   end

   assign atom_out = atom_ff;
endmodule

@@ rtl/cnts_pair.sv @@
// Pair distance pipeline: wrap, square, sum and shell test.
module cnts_pair (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  cnts_pkg::atom_slot_type              center,
   input  cnts_pkg::atom_slot_type              other,
   input  logic [cnts_pkg::CoordWidth-1:0]      box_x,
   input  logic [cnts_pkg::CoordWidth-1:0]      box_y,
   input  logic [cnts_pkg::CoordWidth-1:0]      box_z,
   input  logic [cnts_pkg::CutSqWidth-1:0]      inner_sq,
   input  logic [cnts_pkg::CutSqWidth-1:0]      outer_sq,
   input  cnts_pkg::tag_type                    tag_in,
   output cnts_pkg::tag_type                    tag_out,
   output logic                                 hit,
   output logic                                 busy
);
   localparam int DW = cnts_pkg::DiffWidth;

   function automatic logic signed [DW-1:0] wrap_diff(
      input logic [cnts_pkg::CoordWidth-1:0] a,
      input logic [cnts_pkg::CoordWidth-1:0] b,
      input logic [cnts_pkg::CoordWidth-1:0] box
   );
      logic signed [DW:0] d;
      logic signed [DW:0] d2;
      logic signed [DW:0] bl;
      d  = signed'({3'b000, b}) - signed'({3'b000, a});
      d2 = d <<< 1;
      bl = signed'({3'b000, box});
      if (d2 > bl) begin
         d = d - bl;
      end else if (d2 < -bl) begin
         d = d + bl;
      end
      return d[DW-1:0];
   endfunction

   logic signed [DW-1:0]                 dx_ff, dy_ff, dz_ff;
   logic signed [cnts_pkg::SqWidth-1:0]  sx_ff, sy_ff, sz_ff;
   cnts_pkg::tag_type                    t1_ff, t2_ff, t3_ff;
   logic                                 hit_ff;
   logic [cnts_pkg::SumWidth-1:0]        sum;

   assign sum = cnts_pkg::SumWidth'(unsigned'(sx_ff)) + cnts_pkg::SumWidth'(unsigned'(sy_ff))
              + cnts_pkg::SumWidth'(unsigned'(sz_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= wrap_diff(center.x, other.x, box_x);
         dy_ff  <= wrap_diff(center.y, other.y, box_y);
         dz_ff  <= wrap_diff(center.z, other.z, box_z);
         sx_ff  <= dx_ff * dx_ff;
         sy_ff  <= dy_ff * dy_ff;
         sz_ff  <= dz_ff * dz_ff;
         hit_ff <= (sum > cnts_pkg::SumWidth'(inner_sq)) &&
                   (sum <= cnts_pkg::SumWidth'(outer_sq));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         t3_ff <= '0;
      end else if (en) begin
         t1_ff <= tag_in;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
      end
   end

   assign tag_out = t3_ff;
   assign hit     = hit_ff;
   assign busy    = t1_ff.valid | t2_ff.valid | t3_ff.valid;
endmodule

@@ rtl/coordination_number_two_species.sv @@
// Top level: atom ring, pair pipeline, frame control and register port.
// Load: one atom per cycle while no result waits; the closing atom starts the frame
// computation, or gives a none-found result if no center-species atom was loaded.
// Compute: one pair per cycle while the result channel is not stalled, through a single
// pair pipeline fed by a ring rotating one slot per cycle while not stalled.
// Synchronous active-high reset clears control and registers; slots are not cleared.
module coordination_number_two_species #(
   parameter int MAX_ATOMS = cnts_pkg::MaxAtoms
) (
   input  logic                               clock,
   input  logic                               reset,
   cnts_req_if.sink                           req_chan,
   cnts_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cnts_pkg::AddrWidth-1:0]     csr_paddr,
   input  logic [cnts_pkg::DataWidth-1:0]     csr_pwdata,
   output logic [cnts_pkg::DataWidth-1:0]     csr_prdata,
   output logic                               csr_pready
);
   localparam int IW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
   localparam int CW = $clog2(MAX_ATOMS + 1);
   localparam int CD = cnts_pkg::CoordWidth;
   localparam int SD = cnts_pkg::SpecWidth;
   localparam int OW = cnts_pkg::OutWidth;

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CD-1:0] box_x_ff, box_y_ff, box_z_ff, inner_ff, outer_ff;
   logic [SD-1:0] cspec_ff, nspec_ff;
   logic [cnts_pkg::CutSqWidth-1:0] inner_sq_ff, outer_sq_ff;

   logic [CW-1:0] n_ff, n_in, cc_ff, cc_in, rev_ff, rev_in, rank_ff, rank_in;
   logic [IW-1:0] t_ff, t_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   cnts_pkg::atom_slot_type center_ff, center_in, next_ff, next_in;

   logic          ov_ff, ov_in;
   logic [OW-1:0] o_idx_ff, o_idx_in, o_cnt_ff, o_cnt_in;
   logic          o_last_ff, o_last_in, o_none_ff, o_none_in;

   logic en, req_acc, store, shift, rev_end, pair_hit, pair_busy;
   logic [CW-1:0] off, tc, j;
   logic j_ok;
   cnts_pkg::atom_slot_type req_atom, head;
   cnts_pkg::atom_slot_type ring [MAX_ATOMS];
   cnts_pkg::tag_type  tag_issue, tag_done;

   // register port
   logic          csr_wr;
   logic [2:0]    csr_idx;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= '1;
         box_y_ff <= '1;
         box_z_ff <= '1;
         inner_ff <= '0;
         outer_ff <= '0;
         cspec_ff <= '0;
         nspec_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            cnts_pkg::RegBoxX:      box_x_ff <= csr_pwdata[CD-1:0];
            cnts_pkg::RegBoxY:      box_y_ff <= csr_pwdata[CD-1:0];
            cnts_pkg::RegBoxZ:      box_z_ff <= csr_pwdata[CD-1:0];
            cnts_pkg::RegInner:     inner_ff <= csr_pwdata[CD-1:0];
            cnts_pkg::RegOuter:     outer_ff <= csr_pwdata[CD-1:0];
            cnts_pkg::RegCenterSpc: cspec_ff <= csr_pwdata[SD-1:0];
            cnts_pkg::RegNbrSpc:    nspec_ff <= csr_pwdata[SD-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         cnts_pkg::RegBoxX:      csr_prdata = 32'(box_x_ff);
         cnts_pkg::RegBoxY:      csr_prdata = 32'(box_y_ff);
         cnts_pkg::RegBoxZ:      csr_prdata = 32'(box_z_ff);
         cnts_pkg::RegInner:     csr_prdata = 32'(inner_ff);
         cnts_pkg::RegOuter:     csr_prdata = 32'(outer_ff);
         cnts_pkg::RegCenterSpc: csr_prdata = 32'(cspec_ff);
         cnts_pkg::RegNbrSpc:    csr_prdata = 32'(nspec_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      inner_sq_ff <= inner_ff * inner_ff;
      outer_sq_ff <= outer_ff * outer_ff;
   end

   // ring of atom slots
   assign req_atom = '{x: req_chan.coord_x, y: req_chan.coord_y, z: req_chan.coord_z,
                       species: req_chan.species};
   assign en       = !ov_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_LOAD) && !ov_ff;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign store    = req_acc && (n_ff < CW'(MAX_ATOMS));
   assign shift    = store || ((state_ff == ST_RUN) && en);
   assign head     = ring[MAX_ATOMS-1];

   for (genvar k = 0; k < MAX_ATOMS; k++) begin : g_ring
      cnts_pkg::atom_slot_type cell_in;
      if (k == 0) begin : g_head
         assign cell_in = (state_ff == ST_LOAD) ? req_atom : ring[MAX_ATOMS-1];
      end else begin : g_body
         assign cell_in = ring[k-1];
      end
      cnts_cell u_cell (
         .clock   (clock),
         .shift   (shift),
         .atom_in (cell_in),
         .atom_out(ring[k])
      );
   end

   // slot at the head holds load index j = t - (MAX_ATOMS - n)
   assign off     = CW'(MAX_ATOMS) - n_ff;
   assign tc      = CW'(t_ff);
   assign j_ok    = tc >= off;
   assign j       = tc - off;
   assign rev_end = t_ff == IW'(MAX_ATOMS - 1);

   always_comb begin
      tag_issue.valid     = (state_ff == ST_RUN) && (rev_ff != '0);
      tag_issue.pair_ok   = j_ok && (j != rev_ff - 1'b1) && (head.species == nspec_ff);
      tag_issue.last_step = rev_end;
      tag_issue.is_center = center_ff.species == cspec_ff;
   end

   cnts_pair u_pair (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .center  (center_ff),
      .other   (head),
      .box_x   (box_x_ff),
      .box_y   (box_y_ff),
      .box_z   (box_z_ff),
      .inner_sq(inner_sq_ff),
      .outer_sq(outer_sq_ff),
      .tag_in  (tag_issue),
      .tag_out (tag_done),
      .hit     (pair_hit),
      .busy    (pair_busy)
   );

   // frame control
   always_comb begin
      logic          is_c;
      logic [CW-1:0] cc_new;
      logic [OW-1:0] cnt_sum;
      state_in  = state_ff;
      n_in      = n_ff;
      cc_in     = cc_ff;
      rev_in    = rev_ff;
      t_in      = t_ff;
      rank_in   = rank_ff;
      cnt_in    = cnt_ff;
      center_in = center_ff;
      next_in   = next_ff;
      ov_in     = ov_ff && !rsp_chan.ready;
      o_idx_in  = o_idx_ff;
      o_cnt_in  = o_cnt_ff;
      o_last_in = o_last_ff;
      o_none_in = o_none_ff;
      is_c      = store && (req_chan.species == cspec_ff);
      cc_new    = cc_ff + CW'(is_c);
      cnt_sum   = cnt_ff + OW'(tag_done.pair_ok && pair_hit);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               n_in  = n_ff + CW'(store);
               cc_in = cc_new;
               if (req_chan.last_atom) begin
                  if (cc_new == '0) begin
                     ov_in     = 1'b1;
                     o_idx_in  = '0;
                     o_cnt_in  = '0;
                     o_last_in = 1'b1;
                     o_none_in = 1'b1;
                     n_in      = '0;
                  end else begin
                     state_in = ST_RUN;
                     t_in     = '0;
                     rev_in   = '0;
                     rank_in  = '0;
                     cnt_in   = '0;
                  end
               end
            end
         end
         ST_RUN: begin
            if (en) begin
               t_in = rev_end ? '0 : t_ff + 1'b1;
               if (j_ok && (j == rev_ff)) begin
                  next_in = head;
               end
               if (rev_end) begin
                  rev_in    = rev_ff + 1'b1;
                  center_in = next_in;
                  if (rev_ff == n_ff) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!pair_busy) begin
               state_in = ST_LOAD;
               n_in     = '0;
               cc_in    = '0;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (en && tag_done.valid) begin
         cnt_in = cnt_sum;
         if (tag_done.last_step) begin
            cnt_in = '0;
            if (tag_done.is_center) begin
               ov_in     = 1'b1;
               o_idx_in  = OW'(rank_ff);
               o_cnt_in  = cnt_sum;
               o_last_in = rank_ff == cc_ff - 1'b1;
               o_none_in = 1'b0;
               rank_in   = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         n_ff     <= '0;
         cc_ff    <= '0;
         rev_ff   <= '0;
         t_ff     <= '0;
         rank_ff  <= '0;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         cc_ff    <= cc_in;
         rev_ff   <= rev_in;
         t_ff     <= t_in;
         rank_ff  <= rank_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
      next_ff   <= next_in;
      o_idx_ff  <= o_idx_in;
      o_cnt_ff  <= o_cnt_in;
      o_last_ff <= o_last_in;
      o_none_ff <= o_none_in;
   end

   assign rsp_chan.valid          = ov_ff;
   assign rsp_chan.center_index   = o_idx_ff;
   assign rsp_chan.neighbor_count = o_cnt_ff;
   assign rsp_chan.last_result    = o_last_ff;
   assign rsp_chan.none_found     = o_none_ff;
endmodule

@@ rtl/cnts_checker.sv @@
// Port-level assertions for the coordination counter, bound to the top level.
module cnts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [cnts_pkg::OutWidth-1:0] rsp_index,
   input logic [cnts_pkg::OutWidth-1:0] rsp_count,
   input logic                          rsp_last,
   input logic                          rsp_none
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_count)
         && $stable(rsp_last) && $stable(rsp_none))
      else $error("result word changed while stalled");

   a_none_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none |-> rsp_last && (rsp_index == '0) && (rsp_count == '0))
      else $error("none-found word malformed");

   a_no_load_while_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("input taken while a result waits");

   a_frame_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input ready before frame finished");
endmodule

bind coordination_number_two_species cnts_checker u_cnts_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_index(rsp_chan.center_index),
   .rsp_count(rsp_chan.neighbor_count),
   .rsp_last (rsp_chan.last_result),
   .rsp_none (rsp_chan.none_found)
);
